// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the keypoint selector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define KPS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define KPS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/kps_pkg.sv =====
// Shared types and constants of the image region keypoint selector.
`timescale 1ns / 1ps
`default_nettype none

package kps_pkg;

   localparam int NUM_SLOTS  = 5;
   localparam int POS_W      = 16;
   localparam int REG_W      = 13;
   localparam int CTR_W      = 12;   // integer bits of a centre coordinate
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [REG_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [REG_W-1:0] HEIGHT_RESET = 13'd480;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_OFFER  = 2'd1,
      OP_REMOVE = 2'd2
   } kps_op_type;

   typedef enum logic {
      CSR_IDX_WIDTH  = 1'b0,
      CSR_IDX_HEIGHT = 1'b1
   } kps_csr_idx_type;

   typedef logic [2:0] kps_slot_type;

   localparam kps_slot_type SLOT_CENTRE = 3'd0;
   localparam kps_slot_type SLOT_BR     = 3'd1;
   localparam kps_slot_type SLOT_TR     = 3'd2;
   localparam kps_slot_type SLOT_TL     = 3'd3;
   localparam kps_slot_type SLOT_BL     = 3'd4;

   typedef struct packed {
      kps_op_type   op;
      kps_slot_type quad;
   } kps_ctrl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/kps_front.sv =====
// Front stage: registers an item with its Chebyshev distance and box area to the centre and its quadrant.
`timescale 1ns / 1ps
`default_nettype none

module kps_front
   import kps_pkg::*;
#(
   parameter int ID_BITS = 16,
   parameter int FRAC_BITS = 4,
   localparam int CX_W = CTR_W + FRAC_BITS,
   localparam int DIFF_W = (CX_W > POS_W) ? CX_W : POS_W,
   localparam int AREA_W = 2 * DIFF_W
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [CX_W-1:0]     cx_i,
   input  logic [CX_W-1:0]     cy_i,
   input  logic                in_valid_i,
   output logic                in_ready_o,
   input  logic [1:0]          op_i,
   input  logic [ID_BITS-1:0]  id_i,
   input  logic [POS_W-1:0]    x_i,
   input  logic [POS_W-1:0]    y_i,
   output logic                out_valid_o,
   input  logic                out_ready_i,
   output kps_ctrl_type        ctrl_o,
   output logic [ID_BITS-1:0]  id_o,
   output logic [POS_W-1:0]    x_o,
   output logic [POS_W-1:0]    y_o,
   output logic [DIFF_W-1:0]   cheb_o,
   output logic [AREA_W-1:0]   area_o
);

   logic                valid_ff;
   kps_ctrl_type        ctrl_ff;
   kps_ctrl_type        ctrl_in;
   logic [ID_BITS-1:0]  id_ff;
   logic [POS_W-1:0]    x_ff;
   logic [POS_W-1:0]    y_ff;
   logic [DIFF_W-1:0]   cheb_ff;
   logic [DIFF_W-1:0]   cheb_in;
   logic [AREA_W-1:0]   area_ff;
   logic [AREA_W-1:0]   area_in;
   logic [DIFF_W-1:0]   x_ext;
   logic [DIFF_W-1:0]   y_ext;
   logic [DIFF_W-1:0]   cx_ext;
   logic [DIFF_W-1:0]   cy_ext;
   logic [DIFF_W-1:0]   dx;
   logic [DIFF_W-1:0]   dy;
   logic                right;
   logic                bottom;
   logic                load;

   assign x_ext  = DIFF_W'(x_i);
   assign y_ext  = DIFF_W'(y_i);
   assign cx_ext = DIFF_W'(cx_i);
   assign cy_ext = DIFF_W'(cy_i);

   assign right  = (x_ext >= cx_ext);
   assign bottom = (y_ext >= cy_ext);
   assign dx     = right  ? (x_ext - cx_ext) : (cx_ext - x_ext);
   assign dy     = bottom ? (y_ext - cy_ext) : (cy_ext - y_ext);

   assign cheb_in = (dx > dy) ? dx : dy;
   assign area_in = AREA_W'(dx) * AREA_W'(dy);

   always_comb begin
      ctrl_in.op = kps_op_type'(op_i);
      if (right && bottom) begin
         ctrl_in.quad = SLOT_BR;
      end else if (right) begin
         ctrl_in.quad = SLOT_TR;
      end else if (!bottom) begin
         ctrl_in.quad = SLOT_TL;
      end else begin
         ctrl_in.quad = SLOT_BL;
      end
   end

   assign in_ready_o = !valid_ff || out_ready_i;
   assign load       = in_valid_i && in_ready_o;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready_o) begin
         valid_ff <= in_valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ctrl_ff <= ctrl_in;
         id_ff   <= id_i;
         x_ff    <= x_i;
         y_ff    <= y_i;
         cheb_ff <= cheb_in;
         area_ff <= area_in;
      end
   end

   assign out_valid_o = valid_ff;
   assign ctrl_o      = ctrl_ff;
   assign id_o        = id_ff;
   assign x_o         = x_ff;
   assign y_o         = y_ff;
   assign cheb_o      = cheb_ff;
   assign area_o      = area_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/kps_cell.sv =====
// One slot cell: holds one keypoint slot and passes each item on to the next cell.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module kps_cell
   import kps_pkg::*;
#(
   parameter int ID_BITS = 16,
   parameter int FRAC_BITS = 4,
   parameter int SLOT = 0,
   localparam int CX_W = CTR_W + FRAC_BITS,
   localparam int DIFF_W = (CX_W > POS_W) ? CX_W : POS_W,
   localparam int AREA_W = 2 * DIFF_W
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [CX_W-1:0]                    cx_i,
   input  logic [CX_W-1:0]                    cy_i,
   input  logic                               in_valid_i,
   output logic                               in_ready_o,
   input  kps_ctrl_type                       ctrl_i,
   input  logic [ID_BITS-1:0]                 id_i,
   input  logic [POS_W-1:0]                   x_i,
   input  logic [POS_W-1:0]                   y_i,
   input  logic [DIFF_W-1:0]                  cheb_i,
   input  logic [AREA_W-1:0]                  area_i,
   input  logic [NUM_SLOTS-1:0]               mask_i,
   input  logic [NUM_SLOTS-1:0][ID_BITS-1:0]  ids_i,
   output logic                               out_valid_o,
   input  logic                               out_ready_i,
   output kps_ctrl_type                       ctrl_o,
   output logic [ID_BITS-1:0]                 id_o,
   output logic [POS_W-1:0]                   x_o,
   output logic [POS_W-1:0]                   y_o,
   output logic [DIFF_W-1:0]                  cheb_o,
   output logic [AREA_W-1:0]                  area_o,
   output logic [NUM_SLOTS-1:0]               mask_o,
   output logic [NUM_SLOTS-1:0][ID_BITS-1:0]  ids_o
);

   // slot state
   logic                               slot_valid_ff;
   logic                               slot_valid_in;
   logic [ID_BITS-1:0]                 slot_id_ff;
   logic [POS_W-1:0]                   slot_x_ff;
   logic [POS_W-1:0]                   slot_y_ff;
   logic [AREA_W-1:0]                  slot_metric_ff;
   logic [AREA_W-1:0]                  slot_metric_in;

   // item stage
   logic                               out_valid_ff;
   kps_ctrl_type                       ctrl_ff;
   logic [ID_BITS-1:0]                 id_ff;
   logic [POS_W-1:0]                   x_ff;
   logic [POS_W-1:0]                   y_ff;
   logic [DIFF_W-1:0]                  cheb_ff;
   logic [AREA_W-1:0]                  area_ff;
   logic [NUM_SLOTS-1:0]               mask_ff;
   logic [NUM_SLOTS-1:0]               mask_in;
   logic [NUM_SLOTS-1:0][ID_BITS-1:0]  ids_ff;
   logic [NUM_SLOTS-1:0][ID_BITS-1:0]  ids_in;

   logic [DIFF_W-1:0]                  sx_ext;
   logic [DIFF_W-1:0]                  sy_ext;
   logic [DIFF_W-1:0]                  cx_ext;
   logic [DIFF_W-1:0]                  cy_ext;
   logic [DIFF_W-1:0]                  sdx;
   logic [DIFF_W-1:0]                  sdy;
   logic [AREA_W-1:0]                  stored_metric;
   logic [AREA_W-1:0]                  cand_metric;
   logic                               better;
   logic                               eligible;
   logic                               take;
   logic                               load;

   assign in_ready_o = !out_valid_ff || out_ready_i;
   assign load       = in_valid_i && in_ready_o;

   // Metric of the held keypoint, recomputed every cycle so that a new centre
   // takes effect without touching the slot.
   assign sx_ext = DIFF_W'(slot_x_ff);
   assign sy_ext = DIFF_W'(slot_y_ff);
   assign cx_ext = DIFF_W'(cx_i);
   assign cy_ext = DIFF_W'(cy_i);
   assign sdx    = (sx_ext >= cx_ext) ? (sx_ext - cx_ext) : (cx_ext - sx_ext);
   assign sdy    = (sy_ext >= cy_ext) ? (sy_ext - cy_ext) : (cy_ext - sy_ext);

   assign stored_metric = (SLOT == SLOT_CENTRE) ? AREA_W'((sdx > sdy) ? sdx : sdy)
                                                : AREA_W'(sdx) * AREA_W'(sdy);
   assign cand_metric   = (SLOT == SLOT_CENTRE) ? AREA_W'(cheb_i) : area_i;

   // Centre slot keeps the closest point, quadrant slots the largest box.
   assign better   = (SLOT == SLOT_CENTRE) ? (cand_metric < slot_metric_ff)
                                           : (cand_metric > slot_metric_ff);
   assign eligible = (SLOT == SLOT_CENTRE) || (ctrl_i.quad == kps_slot_type'(SLOT));

   always_comb begin
      take          = 1'b0;
      slot_valid_in = slot_valid_ff;
      case (ctrl_i.op)
         OP_CLEAR: begin
            slot_valid_in = 1'b0;
         end
         OP_OFFER: begin
            if (eligible && (!slot_valid_ff || better)) begin
               take          = 1'b1;
               slot_valid_in = 1'b1;
            end
         end
         OP_REMOVE: begin
            if (slot_valid_ff && (slot_id_ff == id_i)) begin
               slot_valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   assign slot_metric_in = (load && take) ? cand_metric : stored_metric;

   // Report this slot's state after the item; an empty slot reads zero.
   always_comb begin
      mask_in       = mask_i;
      ids_in        = ids_i;
      mask_in[SLOT] = slot_valid_in;
      if (!slot_valid_in) begin
         ids_in[SLOT] = '0;
      end else if (take) begin
         ids_in[SLOT] = id_i;
      end else begin
         ids_in[SLOT] = slot_id_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (load) begin
            slot_valid_ff <= slot_valid_in;
         end
         if (in_ready_o) begin
            out_valid_ff <= in_valid_i;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_metric_ff <= slot_metric_in;
      if (load && take) begin
         slot_id_ff <= id_i;
         slot_x_ff  <= x_i;
         slot_y_ff  <= y_i;
      end
      if (load) begin
         ctrl_ff <= ctrl_i;
         id_ff   <= id_i;
         x_ff    <= x_i;
         y_ff    <= y_i;
         cheb_ff <= cheb_i;
         area_ff <= area_i;
         mask_ff <= mask_in;
         ids_ff  <= ids_in;
      end
   end

   assign out_valid_o = out_valid_ff;
   assign ctrl_o      = ctrl_ff;
   assign id_o        = id_ff;
   assign x_o         = x_ff;
   assign y_o         = y_ff;
   assign cheb_o      = cheb_ff;
   assign area_o      = area_ff;
   assign mask_o      = mask_ff;
   assign ids_o       = ids_ff;

   `KPS_ASSERT(a_clear_empties, load && (ctrl_i.op == OP_CLEAR) |=> !slot_valid_ff, "slot survived a clear")
   `KPS_ASSERT(a_remove_empties, load && (ctrl_i.op == OP_REMOVE) && slot_valid_ff && (slot_id_ff == id_i) |=> !slot_valid_ff, "slot kept a removed id")
   `KPS_ASSERT(a_mask_tracks_slot, load |=> (mask_ff[SLOT] == slot_valid_ff), "reported mask bit differs from slot state")
   `KPS_ASSERT(a_fill_by_offer, $rose(slot_valid_ff) |-> $past(load && (ctrl_i.op == OP_OFFER)), "slot filled without an offer")

endmodule

`default_nettype wire

// ===== hw/rtl/image_region_keypoint_selector.sv =====
// Top level of the image region keypoint selector: config registers and the slot cell chain.
//
// Usage:
//   req_* carries one item per accepted cycle (req_valid high, req_stall low):
//   op clear, offer a feature at (pos_x, pos_y) in fixed point, or remove an id.
//   rsp_* returns exactly one item per request, in order: the valid mask and the
//   ids of the five slots (centre, bottom-right, top-right, top-left, bottom-left)
//   as they stand after that request. Empty slots report id zero.
//   Path: a request passes one front stage that computes distances and quadrant,
//   then one register stage per slot cell; the last cell's register drives rsp.
//   Throughput: one item per cycle while rsp_stall is low, set by the five-cell
//   chain in which each cell updates its own slot as an item passes through.
//   When the receiver holds rsp_stall, the result holds still; stages behind it
//   keep filling until the chain is full, and only then req_stall rises.
//   csr_* is an APB-style port: image width at byte address 0, height at 4.
//   Write them only while no item is in flight.
//   Reset (synchronous, active high) empties all slots and the chain and sets
//   width 640 and height 480.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module image_region_keypoint_selector
   import kps_pkg::*;
#(
   parameter int ID_BITS = 16,
   parameter int FRAC_BITS = 4
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_op,
   input  logic [ID_BITS-1:0]     req_feature_id,
   input  logic [POS_W-1:0]       req_pos_x,
   input  logic [POS_W-1:0]       req_pos_y,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [NUM_SLOTS-1:0]   rsp_valid_mask,
   output logic [ID_BITS-1:0]     rsp_centre_id,
   output logic [ID_BITS-1:0]     rsp_bottom_right_id,
   output logic [ID_BITS-1:0]     rsp_top_right_id,
   output logic [ID_BITS-1:0]     rsp_top_left_id,
   output logic [ID_BITS-1:0]     rsp_bottom_left_id,

   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int CX_W   = CTR_W + FRAC_BITS;
   localparam int DIFF_W = (CX_W > POS_W) ? CX_W : POS_W;
   localparam int AREA_W = 2 * DIFF_W;

   logic [REG_W-1:0]   width_ff;
   logic [REG_W-1:0]   height_ff;
   logic [CX_W-1:0]    cx;
   logic [CX_W-1:0]    cy;
   logic               csr_write;
   kps_csr_idx_type    csr_idx;

   // Chain buses: index k feeds cell k.
   logic [NUM_SLOTS:0]                     valid_c;
   logic [NUM_SLOTS:0]                     ready_c;
   kps_ctrl_type                           ctrl_c [NUM_SLOTS];
   logic [ID_BITS-1:0]                     id_c   [NUM_SLOTS];
   logic [POS_W-1:0]                       x_c    [NUM_SLOTS];
   logic [POS_W-1:0]                       y_c    [NUM_SLOTS];
   logic [DIFF_W-1:0]                      cheb_c [NUM_SLOTS];
   logic [AREA_W-1:0]                      area_c [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]                   mask_c [NUM_SLOTS+1];
   logic [NUM_SLOTS-1:0][ID_BITS-1:0]      ids_c  [NUM_SLOTS+1];
   logic                                   front_ready;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = kps_csr_idx_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_idx)
            CSR_IDX_WIDTH:  width_ff  <= csr_pwdata[REG_W-1:0];
            CSR_IDX_HEIGHT: height_ff <= csr_pwdata[REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_IDX_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         CSR_IDX_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Centre in position units: half the size, scaled to fixed point.
   assign cx = CX_W'(width_ff[REG_W-1:1]) << FRAC_BITS;
   assign cy = CX_W'(height_ff[REG_W-1:1]) << FRAC_BITS;

   assign req_stall = !front_ready;

   kps_front #(
      .ID_BITS   (ID_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cx_i        (cx),
      .cy_i        (cy),
      .in_valid_i  (req_valid),
      .in_ready_o  (front_ready),
      .op_i        (req_op),
      .id_i        (req_feature_id),
      .x_i         (req_pos_x),
      .y_i         (req_pos_y),
      .out_valid_o (valid_c[0]),
      .out_ready_i (ready_c[0]),
      .ctrl_o      (ctrl_c[0]),
      .id_o        (id_c[0]),
      .x_o         (x_c[0]),
      .y_o         (y_c[0]),
      .cheb_o      (cheb_c[0]),
      .area_o      (area_c[0])
   );

   assign mask_c[0] = '0;
   assign ids_c[0]  = '0;

   for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
      if (k < NUM_SLOTS - 1) begin : g_mid
         kps_cell #(
            .ID_BITS   (ID_BITS),
            .FRAC_BITS (FRAC_BITS),
            .SLOT      (k)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .cx_i        (cx),
            .cy_i        (cy),
            .in_valid_i  (valid_c[k]),
            .in_ready_o  (ready_c[k]),
            .ctrl_i      (ctrl_c[k]),
            .id_i        (id_c[k]),
            .x_i         (x_c[k]),
            .y_i         (y_c[k]),
            .cheb_i      (cheb_c[k]),
            .area_i      (area_c[k]),
            .mask_i      (mask_c[k]),
            .ids_i       (ids_c[k]),
            .out_valid_o (valid_c[k+1]),
            .out_ready_i (ready_c[k+1]),
            .ctrl_o      (ctrl_c[k+1]),
            .id_o        (id_c[k+1]),
            .x_o         (x_c[k+1]),
            .y_o         (y_c[k+1]),
            .cheb_o      (cheb_c[k+1]),
            .area_o      (area_c[k+1]),
            .mask_o      (mask_c[k+1]),
            .ids_o       (ids_c[k+1])
         );
      end else begin : g_last
         kps_cell #(
            .ID_BITS   (ID_BITS),
            .FRAC_BITS (FRAC_BITS),
            .SLOT      (k)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .cx_i        (cx),
            .cy_i        (cy),
            .in_valid_i  (valid_c[k]),
            .in_ready_o  (ready_c[k]),
            .ctrl_i      (ctrl_c[k]),
            .id_i        (id_c[k]),
            .x_i         (x_c[k]),
            .y_i         (y_c[k]),
            .cheb_i      (cheb_c[k]),
            .area_i      (area_c[k]),
            .mask_i      (mask_c[k]),
            .ids_i       (ids_c[k]),
            .out_valid_o (valid_c[k+1]),
            .out_ready_i (ready_c[k+1]),
            .ctrl_o      (),
            .id_o        (),
            .x_o         (),
            .y_o         (),
            .cheb_o      (),
            .area_o      (),
            .mask_o      (mask_c[k+1]),
            .ids_o       (ids_c[k+1])
         );
      end
   end

   // The last cell's stage is the result register.
   assign ready_c[NUM_SLOTS] = !rsp_stall;
   assign rsp_valid          = valid_c[NUM_SLOTS];
   assign rsp_valid_mask     = mask_c[NUM_SLOTS];
   assign rsp_centre_id       = ids_c[NUM_SLOTS][SLOT_CENTRE];
   assign rsp_bottom_right_id = ids_c[NUM_SLOTS][SLOT_BR];
   assign rsp_top_right_id    = ids_c[NUM_SLOTS][SLOT_TR];
   assign rsp_top_left_id     = ids_c[NUM_SLOTS][SLOT_TL];
   assign rsp_bottom_left_id  = ids_c[NUM_SLOTS][SLOT_BL];

   `KPS_ASSERT(a_empty_chain_accepts, !rsp_valid |-> !req_stall,
      "input stalled while no result is pending")
   `KPS_ASSERT(a_width_write,
      csr_write && (csr_idx == CSR_IDX_WIDTH) |=> (width_ff == $past(csr_pwdata[REG_W-1:0])),
      "width register missed a write")
   `KPS_ASSERT(a_empty_centre_zero,
      rsp_valid && !rsp_valid_mask[SLOT_CENTRE] |-> (rsp_centre_id == '0),
      "empty centre slot reports a nonzero id")

endmodule

`default_nettype wire

// ===== dv/image_region_keypoint_selector_checker.sv =====
// Checker for the keypoint selector: tracks slots and registers, predicts and compares results.
`timescale 1ns / 1ps

module image_region_keypoint_selector_checker
   import kps_pkg::*;
#(
   parameter int ID_BITS = 16,
   parameter int FRAC_BITS = 4
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [1:0]             req_op,
   input  logic [ID_BITS-1:0]     req_feature_id,
   input  logic [POS_W-1:0]       req_pos_x,
   input  logic [POS_W-1:0]       req_pos_y,

   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [NUM_SLOTS-1:0]   rsp_valid_mask,
   input  logic [ID_BITS-1:0]     rsp_centre_id,
   input  logic [ID_BITS-1:0]     rsp_bottom_right_id,
   input  logic [ID_BITS-1:0]     rsp_top_right_id,
   input  logic [ID_BITS-1:0]     rsp_top_left_id,
   input  logic [ID_BITS-1:0]     rsp_bottom_left_id,

   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   input  logic [CSR_DATA_W-1:0]  csr_prdata,
   input  logic                   csr_pready,

   output int unsigned            pending_reports,
   output int unsigned            mismatch_count
);

   typedef struct packed {
      logic [NUM_SLOTS-1:0]              mask;
      logic [NUM_SLOTS-1:0][ID_BITS-1:0] ids;
   } slot_report_type;

   logic [REG_W-1:0]   img_width;
   logic [REG_W-1:0]   img_height;
   logic               slot_full [NUM_SLOTS];
   logic [ID_BITS-1:0] slot_id   [NUM_SLOTS];
   logic [POS_W-1:0]   slot_px   [NUM_SLOTS];
   logic [POS_W-1:0]   slot_py   [NUM_SLOTS];

   slot_report_type expected_reports [$];
   int unsigned     bad_count;

   function automatic logic [POS_W:0] centre_of(logic [REG_W-1:0] extent);
      logic [POS_W:0] half;
      half = {{(POS_W+1-REG_W){1'b0}}, extent} >> 1;
      return half << FRAC_BITS;
   endfunction

   function automatic logic [POS_W:0] gap(logic [POS_W:0] a, logic [POS_W:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   function automatic logic [POS_W:0] ring_dist(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                                logic [POS_W:0] cx, logic [POS_W:0] cy);
      logic [POS_W:0] dx, dy;
      dx = gap({1'b0, px}, cx);
      dy = gap({1'b0, py}, cy);
      return (dx > dy) ? dx : dy;
   endfunction

   function automatic logic [2*POS_W+1:0] box_area(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                                   logic [POS_W:0] cx, logic [POS_W:0] cy);
      logic [POS_W:0] dx, dy;
      dx = gap({1'b0, px}, cx);
      dy = gap({1'b0, py}, cy);
      return (2*POS_W+2)'(dx) * (2*POS_W+2)'(dy);
   endfunction

   function automatic void claim_slot(kps_slot_type k, logic [ID_BITS-1:0] id,
                                      logic [POS_W-1:0] px, logic [POS_W-1:0] py);
      slot_full[k] = 1'b1;
      slot_id[k]   = id;
      slot_px[k]   = px;
      slot_py[k]   = py;
   endfunction

   function automatic void empty_all_slots();
      for (int k = 0; k < NUM_SLOTS; k++) begin
         slot_full[k] = 1'b0;
         slot_id[k]   = '0;
         slot_px[k]   = '0;
         slot_py[k]   = '0;
      end
   endfunction

   function automatic void offer_feature(logic [ID_BITS-1:0] id, logic [POS_W-1:0] px,
                                         logic [POS_W-1:0] py);
      logic [POS_W:0] cx, cy;
      logic           right, bottom;
      kps_slot_type   quad;
      cx = centre_of(img_width);
      cy = centre_of(img_height);
      right  = {1'b0, px} >= cx;
      bottom = {1'b0, py} >= cy;
      if (!slot_full[SLOT_CENTRE] ||
          ring_dist(px, py, cx, cy) <
          ring_dist(slot_px[SLOT_CENTRE], slot_py[SLOT_CENTRE], cx, cy)) begin
         claim_slot(SLOT_CENTRE, id, px, py);
      end
      if (right && bottom)
         quad = SLOT_BR;
      else if (right)
         quad = SLOT_TR;
      else if (!bottom)
         quad = SLOT_TL;
      else
         quad = SLOT_BL;
      if (!slot_full[quad] ||
          box_area(px, py, cx, cy) > box_area(slot_px[quad], slot_py[quad], cx, cy)) begin
         claim_slot(quad, id, px, py);
      end
   endfunction

   function automatic slot_report_type slots_after(logic [1:0] op, logic [ID_BITS-1:0] id,
                                                   logic [POS_W-1:0] px, logic [POS_W-1:0] py);
      slot_report_type rep;
      case (op)
         OP_CLEAR: begin
            empty_all_slots();
         end
         OP_OFFER: begin
            offer_feature(id, px, py);
         end
         OP_REMOVE: begin
            for (int k = 0; k < NUM_SLOTS; k++)
               if (slot_full[k] && slot_id[k] == id) slot_full[k] = 1'b0;
         end
         default: ;
      endcase
      rep = '0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
         if (slot_full[k]) begin
            rep.mask[k] = 1'b1;
            rep.ids[k]  = slot_id[k];
         end
      end
      return rep;
   endfunction

   always @(posedge clock) begin : track
      slot_report_type got;
      slot_report_type want;
      logic [CSR_DATA_W-1:0] reg_value;
      if (reset) begin
         img_width  = WIDTH_RESET;
         img_height = HEIGHT_RESET;
         empty_all_slots();
         expected_reports.delete();
         bad_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[2] == CSR_IDX_WIDTH)
                  img_width = csr_pwdata[REG_W-1:0];
               else
                  img_height = csr_pwdata[REG_W-1:0];
            end else begin
               reg_value = '0;
               reg_value[REG_W-1:0] = (csr_paddr[2] == CSR_IDX_WIDTH) ? img_width : img_height;
               if (csr_prdata !== reg_value) begin
                  if (bad_count < 10)
                     $display("%0t: register read at %0d: expected %h, got %h",
                              $realtime, csr_paddr, reg_value, csr_prdata);
                  bad_count++;
               end
            end
         end

         // Compare before queueing so a result never matches the item of the same edge.
         if (rsp_valid && !rsp_stall) begin
            got.mask = rsp_valid_mask;
            got.ids  = {rsp_bottom_left_id, rsp_top_left_id, rsp_top_right_id,
                        rsp_bottom_right_id, rsp_centre_id};
            if (expected_reports.size() == 0) begin
               if (bad_count < 10)
                  $display("%0t: unexpected result, mask %b", $realtime, got.mask);
               bad_count++;
            end else begin
               want = expected_reports.pop_front();
               if (got !== want) begin
                  if (bad_count < 10)
                     $display({"%0t: slot mismatch: expected mask %b ids %h %h %h %h %h,",
                               " got mask %b ids %h %h %h %h %h"}, $realtime,
                              want.mask, want.ids[0], want.ids[1], want.ids[2],
                              want.ids[3], want.ids[4],
                              got.mask, got.ids[0], got.ids[1], got.ids[2],
                              got.ids[3], got.ids[4]);
                  bad_count++;
               end
            end
         end

         if (req_valid && !req_stall)
            expected_reports.insert(expected_reports.size(),
                                    slots_after(req_op, req_feature_id,
                                                req_pos_x, req_pos_y));
      end
      pending_reports <= expected_reports.size();
      mismatch_count  <= bad_count;
   end

endmodule

// ===== dv/image_region_keypoint_selector_tb.sv =====
// Testbench top for the keypoint selector: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps

module image_region_keypoint_selector_tb;
   import kps_pkg::*;

   localparam int ID_BITS   = 16;
   localparam int FRAC_BITS = 4;
   localparam int NUM_PHASES = 7;
   localparam int ITEMS_PER_PHASE = 110;
   localparam int STALL_LIMIT = 2000;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] ADDR_WIDTH  = {CSR_IDX_WIDTH, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_HEIGHT = {CSR_IDX_HEIGHT, 2'b00};

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_op;
   logic [ID_BITS-1:0]    req_feature_id;
   logic [POS_W-1:0]      req_pos_x;
   logic [POS_W-1:0]      req_pos_y;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [NUM_SLOTS-1:0]  rsp_valid_mask;
   logic [ID_BITS-1:0]    rsp_centre_id;
   logic [ID_BITS-1:0]    rsp_bottom_right_id;
   logic [ID_BITS-1:0]    rsp_top_right_id;
   logic [ID_BITS-1:0]    rsp_top_left_id;
   logic [ID_BITS-1:0]    rsp_bottom_left_id;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int unsigned pending_reports;
   int unsigned mismatch_count;
   int unsigned quiet_cycles;
   logic        gaps_on;
   logic [REG_W-1:0] cur_width;
   logic [REG_W-1:0] cur_height;
   logic [POS_W-1:0] last_x;
   logic [POS_W-1:0] last_y;
   logic [ID_BITS-1:0] recent_ids [$];

   image_region_keypoint_selector #(
      .ID_BITS   (ID_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_dut (.*);

   image_region_keypoint_selector_checker #(
      .ID_BITS   (ID_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_checker (.*);

   always #1 clock = ~clock;

   // Hold-off watchdog: any accepted item on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("image_region_keypoint_selector_tb: done, errors");
            $finish;
         end
      end
   end

   // Receiver back-pressure in bursts, off in the last phase.
   initial begin
      forever begin
         if (gaps_on && $urandom_range(0, 2) == 0) begin
            @(negedge clock) rsp_stall = 1'b1;
            repeat ($urandom_range(0, 6)) @(negedge clock);
         end
         @(negedge clock) rsp_stall = 1'b0;
         repeat (($urandom_range(0, 15) == 0) ? 40 : $urandom_range(0, 9)) @(negedge clock);
      end
   end

   task automatic send_request(logic [1:0] op, logic [ID_BITS-1:0] id,
                               logic [POS_W-1:0] px, logic [POS_W-1:0] py);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         req_valid      = 1'b0;
         req_op         = 2'($urandom_range(0, 3));
         req_feature_id = ID_BITS'($urandom_range(0, 65535));
         req_pos_x      = POS_W'($urandom_range(0, 65535));
         req_pos_y      = POS_W'($urandom_range(0, 65535));
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end
      @(negedge clock);
      req_valid      = 1'b1;
      req_op         = op;
      req_feature_id = id;
      req_pos_x      = px;
      req_pos_y      = py;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic csr_access(logic wr, logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = wr;
      csr_paddr   = addr;
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // Drain the pipe, then retarget the image size.
   task automatic set_image_size(logic [CSR_DATA_W-1:0] w, logic [CSR_DATA_W-1:0] h);
      @(negedge clock) req_valid = 1'b0;
      while (pending_reports != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_access(1'b1, ADDR_WIDTH, w);
      csr_access(1'b1, ADDR_HEIGHT, h);
      csr_access(1'b0, ADDR_WIDTH, '0);
      csr_access(1'b0, ADDR_HEIGHT, '0);
      cur_width  = w[REG_W-1:0];
      cur_height = h[REG_W-1:0];
   endtask

   function automatic logic [POS_W-1:0] pick_coord(logic [REG_W-1:0] extent,
                                                   logic [POS_W-1:0] last);
      int unsigned centre;
      int unsigned far_end;
      int          near;
      centre  = 32'(extent[REG_W-1:1]) << FRAC_BITS;
      far_end = 32'(extent) * 16;
      if (far_end > 65535) far_end = 65535;
      case ($urandom_range(0, 9))
         0, 1: return POS_W'($urandom_range(0, 65535));
         2: begin
            near = int'(centre) + int'($urandom_range(0, 6)) - 3;
            if (near < 0) near = 0;
            if (near > 65535) near = 65535;
            return POS_W'(near);
         end
         3: return last;
         default: return POS_W'($urandom_range(0, far_end));
      endcase
   endfunction

   task automatic send_random_item();
      int unsigned        roll;
      logic [1:0]         op;
      logic [ID_BITS-1:0] id;
      logic [POS_W-1:0]   px, py;
      roll = $urandom_range(0, 99);
      if (roll < 4)
         op = OP_CLEAR;
      else if (roll < 14)
         op = OP_REMOVE;
      else if (roll < 16)
         op = OP_UNUSED;
      else
         op = OP_OFFER;
      if (op == OP_REMOVE && recent_ids.size() != 0 && $urandom_range(0, 3) != 0)
         id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
      else if ($urandom_range(0, 1) == 0)
         id = ID_BITS'($urandom_range(0, 31));
      else
         id = ID_BITS'($urandom_range(0, 65535));
      px = pick_coord(cur_width, last_x);
      py = pick_coord(cur_height, last_y);
      last_x = px;
      last_y = py;
      if (op == OP_OFFER) begin
         recent_ids.insert(recent_ids.size(), id);
         if (recent_ids.size() > 8) void'(recent_ids.pop_front());
      end
      send_request(op, id, px, py);
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] w, h;
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_op         = OP_CLEAR;
      req_feature_id = '0;
      req_pos_x      = '0;
      req_pos_y      = '0;
      rsp_stall      = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      gaps_on        = 1'b1;
      cur_width      = WIDTH_RESET;
      cur_height     = HEIGHT_RESET;
      last_x         = '0;
      last_y         = '0;
      quiet_cycles   = 0;
      repeat (7) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // Directed part at the reset size 640x480: centre is (0x1400, 0x0f00).
      send_request(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(OP_REMOVE, 16'h0000, 16'h0000, 16'h0000);
      send_request(OP_OFFER,  16'h0001, 16'h1400, 16'h0F00);
      send_request(OP_OFFER,  16'h0002, 16'h1400, 16'h0F00);   // tie: no replace
      send_request(OP_OFFER,  16'hFFFF, 16'h0000, 16'h0000);
      send_request(OP_OFFER,  16'h0000, 16'hFFFF, 16'hFFFF);
      send_request(OP_OFFER,  16'h00A5, 16'hFFFF, 16'h0000);
      send_request(OP_OFFER,  16'h5A00, 16'h0000, 16'hFFFF);
      send_request(OP_OFFER,  16'h0003, 16'h1401, 16'h0F00);
      send_request(OP_OFFER,  16'h0004, 16'h1400, 16'h0EFF);
      send_request(OP_OFFER,  16'h0005, 16'h13FF, 16'h0EFF);
      send_request(OP_REMOVE, 16'hFFFF, 16'h1234, 16'h4321);
      send_request(OP_OFFER,  16'h0006, 16'h13FF, 16'h0EFF);
      send_request(OP_OFFER,  16'h0006, 16'h13FE, 16'h0EFE);   // same id, larger area
      send_request(OP_REMOVE, 16'h0001, 16'h0000, 16'h0000);
      send_request(OP_OFFER,  16'h0007, 16'h1410, 16'h0F10);
      send_request(OP_REMOVE, 16'h0000, 16'hFFFF, 16'hFFFF);
      send_request(OP_CLEAR,  16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(OP_UNUSED, 16'h0000, 16'h0000, 16'h0000);
      send_request(OP_OFFER,  16'hBEEF, 16'h1410, 16'h0F10);   // lands in two slots
      send_request(OP_REMOVE, 16'hBEEF, 16'h0000, 16'h0000);
      send_request(OP_OFFER,  16'h1234, 16'h1400, 16'h0F00);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin w = 32'd2;         h = 32'd2;         end
            1: begin w = 32'd4096;      h = 32'd4096;      end
            2: begin w = 32'hFFFF_E000; h = 32'hFFFF_E001; end   // centre at 0
            3: begin w = 32'hFFFF_FFFF; h = 32'hFFFF_FFFF; end
            4, 5: begin
               w = $urandom_range(2, 4096);
               h = $urandom_range(2, 4096);
            end
            default: begin w = 32'd640; h = 32'd480; end
         endcase
         set_image_size(w, h);
         gaps_on = (phase != NUM_PHASES - 1);
         repeat (ITEMS_PER_PHASE) send_random_item();
      end

      @(negedge clock) req_valid = 1'b0;
      while (pending_reports != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && pending_reports == 0)
         $display("image_region_keypoint_selector_tb: done, clean");
      else
         $display("image_region_keypoint_selector_tb: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/kps_pkg.sv
hw/rtl/kps_front.sv
hw/rtl/kps_cell.sv
hw/rtl/image_region_keypoint_selector.sv
dv/image_region_keypoint_selector_checker.sv
dv/image_region_keypoint_selector_tb.sv
